// ===== rtl/eslfu_pkg.sv =====
// Shared types, field widths and codes for the expert slot LFU cache policy.
package eslfu_pkg;

   // Default geometry
   localparam int N_SLOTS_DEF  = 16;
   localparam int N_LAYERS_DEF = 64;

   // Request and response field widths
   localparam int REQ_TYPE_W = 1;
   localparam int LAYER_W    = 6;
   localparam int EXPERT_W   = 10;
   localparam int SLOT_W     = 4;
   localparam int STATUS_W   = 2;
   localparam int CSR_W      = 5;

   // Per-slot bookkeeping widths
   localparam int FREQ_W = 16;
   localparam int TICK_W = 32;

   localparam logic [CSR_W-1:0] CSR_RESET = 5'd16;

   // Request kinds
   localparam logic [REQ_TYPE_W-1:0] REQ_LOOKUP = 1'b0;
   localparam logic [REQ_TYPE_W-1:0] REQ_DONE   = 1'b1;

   // Response status codes
   localparam logic [STATUS_W-1:0] ST_HIT    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_REPEAT = 2'd1;
   localparam logic [STATUS_W-1:0] ST_MISS   = 2'd2;
   localparam logic [STATUS_W-1:0] ST_NOVIC  = 2'd3;

   // One slot entry as held in the slot memory
   typedef struct packed {
      logic                valid;
      logic [EXPERT_W-1:0] expert;
      logic [FREQ_W-1:0]   freq;
      logic [TICK_W-1:0]   used_tick;
   } ent_type;

   // Controller to datapath commands
   typedef struct packed {
      logic clr_step;   // clear one entry of the sweep after reset
      logic capture;    // take in the request payload
      logic layer_rd;   // read per-layer marks and tick, reset scan
      logic scan_step;  // read the next slot of the layer
      logic commit;     // write back the update and load the response
   } cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic clr_last;     // last entry of the clear sweep
      logic direct;       // done request or layer out of range
      logic active_zero;  // no slot to search
      logic scan_last;    // last active slot being read
   } sts_type;

endpackage

// ===== rtl/eslfu_if.sv =====
// Request and response channel interfaces.
interface eslfu_req_if import eslfu_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [REQ_TYPE_W-1:0] req_type;
   logic [LAYER_W-1:0]    layer;
   logic [EXPERT_W-1:0]   expert;
   logic                  new_round;

   modport source (output valid, req_type, layer, expert, new_round, input ready);
   modport sink   (input valid, req_type, layer, expert, new_round, output ready);
endinterface

interface eslfu_rsp_if import eslfu_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [SLOT_W-1:0]   slot;
   logic [STATUS_W-1:0] status;

   modport source (output valid, slot, status, input ready);
   modport sink   (input valid, slot, status, output ready);
endinterface

// ===== rtl/expert_slot_lfu_cache_policy.sv =====
// Top level of the expert slot cache with LFU replacement and LRU tie-break.
// Usage:
//  - req_chan carries one request: a lookup of an expert in a layer's slots,
//    or a done request that clears the in-flight marks of that layer.
//  - rsp_chan returns exactly one response per request: the slot and a status
//    (counted hit or done, repeat hit, miss allocated, no victim).
//  - csr_wr_en/csr_wr_data set the number of active slots per layer; write it
//    only while no request is in progress.
// Timing:
//  - a lookup reads the layer marks, then scans the active slots through the
//    single slot memory read port, one slot per cycle, evaluates the last
//    slot read, then writes back and loads the response. Done requests,
//    out-of-range layers and zero active slots skip the scan.
//  - one request at a time; the next is accepted the cycle after write-back,
//    even while a response still waits.
// Reset: a clearing pass zeroes all N_SLOTS * N_LAYERS slot memory entries,
//  one entry per cycle; no request is taken until it completes. The slot
//  count register returns to 16.
// Stall: if rsp_chan is not ready, the next request's result waits before
//  its write-back until the output register frees up.
module expert_slot_lfu_cache_policy import eslfu_pkg::*; #(
   parameter int N_SLOTS  = N_SLOTS_DEF,
   parameter int N_LAYERS = N_LAYERS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   eslfu_req_if.sink          req_chan,
   eslfu_rsp_if.source        rsp_chan,
   input  logic               csr_wr_en,
   input  logic [CSR_W-1:0]   csr_wr_data
);

   cmd_type cmd;
   sts_type sts;

   // sequencer
   eslfu_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_ready (rsp_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .sts       (sts),
      .cmd       (cmd)
   );

   // memories and compare logic
   eslfu_dp #(
      .N_SLOTS  (N_SLOTS),
      .N_LAYERS (N_LAYERS)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .sts           (sts),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .req_type      (req_chan.req_type),
      .req_layer     (req_chan.layer),
      .req_expert    (req_chan.expert),
      .req_new_round (req_chan.new_round),
      .rsp_slot      (rsp_chan.slot),
      .rsp_status    (rsp_chan.status)
   );

   // one request at a time: ready drops right after acceptance
   a_single_request: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> !req_chan.ready)
      else $error("request accepted while another is in progress");

   // write-back only when the response register can take the result
   a_commit_room: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> (!rsp_chan.valid || rsp_chan.ready))
      else $error("commit would overwrite a pending response");

   // no victim always reports slot zero
   a_novic_slot: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.status == ST_NOVIC) |-> (rsp_chan.slot == '0))
      else $error("no-victim response with nonzero slot");

   // clear sweep and request work never overlap
   a_clear_exclusive: assert property (@(posedge clock) disable iff (reset)
      cmd.clr_step |-> (!req_chan.ready && !cmd.commit))
      else $error("clear sweep overlaps request handling");

endmodule

// ===== rtl/eslfu_ctrl.sv =====
// Sequencer for the slot cache: clear sweep, layer read, slot scan, update.
module eslfu_ctrl import eslfu_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  logic    rsp_ready,
   output logic    rsp_valid,
   input  sts_type sts,
   output cmd_type cmd
);

   localparam logic [2:0] S_CLEAR  = 3'd0;
   localparam logic [2:0] S_IDLE   = 3'd1;
   localparam logic [2:0] S_LREAD  = 3'd2;
   localparam logic [2:0] S_SCAN   = 3'd3;
   localparam logic [2:0] S_DRAIN  = 3'd4;
   localparam logic [2:0] S_UPDATE = 3'd5;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;

   // response register may be refilled when empty or being taken
   assign out_free = !rsp_valid_ff || rsp_ready;

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (sts.clr_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_LREAD;
            end
         end
         S_LREAD: begin
            cmd.layer_rd = 1'b1;
            if (sts.direct || sts.active_zero) state_in = S_UPDATE;
            else                               state_in = S_SCAN;
         end
         S_SCAN: begin
            cmd.scan_step = 1'b1;
            if (sts.scan_last) state_in = S_DRAIN;
         end
         S_DRAIN: begin
            // last slot read is evaluated here
            state_in = S_UPDATE;
         end
         S_UPDATE: begin
            if (out_free) begin
               cmd.commit = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: state_in = S_CLEAR;
      endcase
   end

   // response valid flag
   always_comb begin
      if (cmd.commit)     rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
      else                rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== rtl/eslfu_dp.sv =====
// Datapath: slot and layer memories, scan compare, victim choice, update.
module eslfu_dp import eslfu_pkg::*; #(
   parameter int N_SLOTS  = N_SLOTS_DEF,
   parameter int N_LAYERS = N_LAYERS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  cmd_type               cmd,
   output sts_type               sts,
   input  logic                  csr_wr_en,
   input  logic [CSR_W-1:0]      csr_wr_data,
   input  logic [REQ_TYPE_W-1:0] req_type,
   input  logic [LAYER_W-1:0]    req_layer,
   input  logic [EXPERT_W-1:0]   req_expert,
   input  logic                  req_new_round,
   output logic [SLOT_W-1:0]     rsp_slot,
   output logic [STATUS_W-1:0]   rsp_status
);

   localparam int TOTAL    = N_SLOTS * N_LAYERS;
   localparam int ENTRY_AW = (TOTAL > 1) ? $clog2(TOTAL) : 1;
   localparam int LAYER_AW = (N_LAYERS > 1) ? $clog2(N_LAYERS) : 1;
   localparam int SIDX_W   = (N_SLOTS > 1) ? $clog2(N_SLOTS) : 1;
   localparam int CNT_W    = $clog2(N_SLOTS + 1);

   // memories
   ent_type             ent_mem   [TOTAL];
   logic [N_SLOTS-1:0]  claim_mem [N_LAYERS];
   logic [N_SLOTS-1:0]  infl_mem  [N_LAYERS];
   logic [TICK_W-1:0]   tick_mem  [N_LAYERS];

   // memory read registers
   ent_type             ent_rd_ff;
   logic [N_SLOTS-1:0]  claim_rd_ff;
   logic [N_SLOTS-1:0]  infl_rd_ff;
   logic [TICK_W-1:0]   tick_rd_ff;

   // memory write ports
   logic                ent_we;
   logic [ENTRY_AW-1:0] ent_wa;
   logic [ENTRY_AW-1:0] ent_ra;
   ent_type             ent_wd;
   logic                claim_we, infl_we, tick_we, lay_re;
   logic [LAYER_AW-1:0] lay_wa;
   logic [N_SLOTS-1:0]  claim_wd, infl_wd;
   logic [TICK_W-1:0]   tick_wd;

   // configuration
   logic [CSR_W-1:0]    csr_ff, csr_in;

   // captured request
   logic [REQ_TYPE_W-1:0] type_ff, type_in;
   logic [EXPERT_W-1:0]   expert_ff, expert_in;
   logic                  new_round_ff, new_round_in;
   logic                  oor_ff, oor_in;
   logic [LAYER_AW-1:0]   lidx_ff, lidx_in;
   logic [ENTRY_AW-1:0]   base_ff, base_in;
   logic [CNT_W-1:0]      active_ff, active_in;

   // sweep and scan counters
   logic [ENTRY_AW-1:0]   clr_idx_ff, clr_idx_in;
   logic [SIDX_W-1:0]     scan_idx_ff, scan_idx_in;
   logic [SIDX_W-1:0]     rd_idx_ff, rd_idx_in;
   logic                  rd_vld_ff, rd_vld_in;

   // scan accumulators
   logic                  hit_found_ff, hit_found_in;
   logic [SIDX_W-1:0]     hit_idx_ff, hit_idx_in;
   logic [FREQ_W-1:0]     hit_freq_ff, hit_freq_in;
   logic                  vic_found_ff, vic_found_in;
   logic                  empty_ff, empty_in;
   logic [SIDX_W-1:0]     vic_idx_ff, vic_idx_in;
   logic [FREQ_W-1:0]     vic_freq_ff, vic_freq_in;
   logic [TICK_W-1:0]     vic_lu_ff, vic_lu_in;

   // response registers
   logic [SLOT_W-1:0]     rsp_slot_ff, rsp_slot_in;
   logic [STATUS_W-1:0]   rsp_status_ff, rsp_status_in;

   // update terms
   logic [N_SLOTS-1:0]    claimed_eff;
   logic [N_SLOTS-1:0]    sel_bit;
   logic                  sel;
   logic [SIDX_W-1:0]     sel_slot;
   logic [TICK_W-1:0]     new_tick;
   logic [FREQ_W-1:0]     new_freq;
   logic                  clr_in_layers;

   // configuration register
   assign csr_in = csr_wr_en ? csr_wr_data : csr_ff;

   // request capture; active count clamps to the slot count
   always_comb begin
      type_in      = type_ff;
      expert_in    = expert_ff;
      new_round_in = new_round_ff;
      oor_in       = oor_ff;
      lidx_in      = lidx_ff;
      base_in      = base_ff;
      active_in    = active_ff;
      if (cmd.capture) begin
         type_in      = req_type;
         expert_in    = req_expert;
         new_round_in = req_new_round;
         oor_in       = (32'(req_layer) >= N_LAYERS);
         lidx_in      = LAYER_AW'(req_layer);
         base_in      = ENTRY_AW'(32'(req_layer) * N_SLOTS);
         active_in    = (32'(csr_ff) > N_SLOTS) ? CNT_W'(N_SLOTS) : CNT_W'(csr_ff);
      end
   end

   // counters
   always_comb begin
      clr_idx_in  = cmd.clr_step ? clr_idx_ff + 1'b1 : clr_idx_ff;
      scan_idx_in = scan_idx_ff;
      if (cmd.layer_rd)       scan_idx_in = '0;
      else if (cmd.scan_step) scan_idx_in = scan_idx_ff + 1'b1;
      rd_vld_in = cmd.scan_step;
      rd_idx_in = cmd.scan_step ? scan_idx_ff : rd_idx_ff;
   end

   assign ent_ra        = base_ff + ENTRY_AW'(scan_idx_ff);
   assign clr_in_layers = (32'(clr_idx_ff) < N_LAYERS);
   assign lay_re        = cmd.layer_rd && !oor_ff;

   // claimed marks as seen by this lookup
   assign claimed_eff = new_round_ff ? '0 : claim_rd_ff;

   // status to controller
   always_comb begin
      sts.clr_last    = (clr_idx_ff == ENTRY_AW'(TOTAL - 1));
      sts.direct      = oor_ff || (type_ff == REQ_DONE);
      sts.active_zero = (active_ff == '0);
      sts.scan_last   = ((CNT_W'(scan_idx_ff) + 1'b1) == active_ff);
   end

   // scan evaluation: first hit, and victim (first empty, else LFU then oldest)
   always_comb begin
      hit_found_in = hit_found_ff;
      hit_idx_in   = hit_idx_ff;
      hit_freq_in  = hit_freq_ff;
      vic_found_in = vic_found_ff;
      empty_in     = empty_ff;
      vic_idx_in   = vic_idx_ff;
      vic_freq_in  = vic_freq_ff;
      vic_lu_in    = vic_lu_ff;
      if (cmd.layer_rd) begin
         hit_found_in = 1'b0;
         vic_found_in = 1'b0;
         empty_in     = 1'b0;
      end else if (rd_vld_ff) begin
         if (!hit_found_ff && ent_rd_ff.valid && ent_rd_ff.expert == expert_ff) begin
            hit_found_in = 1'b1;
            hit_idx_in   = rd_idx_ff;
            hit_freq_in  = ent_rd_ff.freq;
         end
         if (!empty_ff && !claimed_eff[rd_idx_ff] && !infl_rd_ff[rd_idx_ff]) begin
            if (!ent_rd_ff.valid) begin
               vic_found_in = 1'b1;
               empty_in     = 1'b1;
               vic_idx_in   = rd_idx_ff;
            end else if (!vic_found_ff || ent_rd_ff.freq < vic_freq_ff ||
                         (ent_rd_ff.freq == vic_freq_ff &&
                          ent_rd_ff.used_tick < vic_lu_ff)) begin
               vic_found_in = 1'b1;
               vic_idx_in   = rd_idx_ff;
               vic_freq_in  = ent_rd_ff.freq;
               vic_lu_in    = ent_rd_ff.used_tick;
            end
         end
      end
   end

   // chosen slot and its new bookkeeping
   assign sel      = hit_found_ff || vic_found_ff;
   assign sel_slot = hit_found_ff ? hit_idx_ff : vic_idx_ff;
   assign new_tick = (tick_rd_ff == '1) ? tick_rd_ff : tick_rd_ff + 1'b1;

   always_comb begin
      if (!hit_found_ff)           new_freq = FREQ_W'(1);
      else if (hit_freq_ff == '1)  new_freq = hit_freq_ff;
      else                         new_freq = hit_freq_ff + 1'b1;
   end

   always_comb begin
      for (int i = 0; i < N_SLOTS; i++) begin
         sel_bit[i] = sel && (SIDX_W'(i) == sel_slot);
      end
   end

   // response value
   always_comb begin
      rsp_slot_in   = rsp_slot_ff;
      rsp_status_in = rsp_status_ff;
      if (cmd.commit) begin
         rsp_slot_in = '0;
         if (oor_ff) begin
            rsp_status_in = (type_ff == REQ_DONE) ? ST_HIT : ST_NOVIC;
         end else if (type_ff == REQ_DONE) begin
            rsp_status_in = ST_HIT;
         end else if (hit_found_ff) begin
            rsp_slot_in   = SLOT_W'(32'(hit_idx_ff));
            rsp_status_in = claimed_eff[hit_idx_ff] ? ST_REPEAT : ST_HIT;
         end else if (vic_found_ff) begin
            rsp_slot_in   = SLOT_W'(32'(vic_idx_ff));
            rsp_status_in = ST_MISS;
         end else begin
            rsp_status_in = ST_NOVIC;
         end
      end
   end

   // memory write selection: clear sweep or commit
   always_comb begin
      ent_we   = 1'b0;
      ent_wa   = clr_idx_ff;
      ent_wd   = '0;
      lay_wa   = LAYER_AW'(clr_idx_ff);
      claim_we = 1'b0;
      infl_we  = 1'b0;
      tick_we  = 1'b0;
      claim_wd = '0;
      infl_wd  = '0;
      tick_wd  = '0;
      if (cmd.clr_step) begin
         ent_we = 1'b1;
         if (clr_in_layers) begin
            claim_we = 1'b1;
            infl_we  = 1'b1;
            tick_we  = 1'b1;
         end
      end else if (cmd.commit && !oor_ff) begin
         lay_wa = lidx_ff;
         if (type_ff == REQ_DONE) begin
            infl_we = 1'b1;
         end else begin
            claim_we = 1'b1;
            claim_wd = claimed_eff | sel_bit;
            if (sel) begin
               tick_we          = 1'b1;
               tick_wd          = new_tick;
               ent_we           = 1'b1;
               ent_wa           = base_ff + ENTRY_AW'(sel_slot);
               ent_wd.valid     = 1'b1;
               ent_wd.expert    = expert_ff;
               ent_wd.freq      = new_freq;
               ent_wd.used_tick = new_tick;
            end
            if (!hit_found_ff && vic_found_ff) begin
               infl_we = 1'b1;
               infl_wd = infl_rd_ff | sel_bit;
            end
         end
      end
   end

   // slot memory
   always_ff @(posedge clock) begin
      if (ent_we) ent_mem[ent_wa] <= ent_wd;
      if (cmd.scan_step) ent_rd_ff <= ent_mem[ent_ra];
   end

   // per-layer memories
   always_ff @(posedge clock) begin
      if (claim_we) claim_mem[lay_wa] <= claim_wd;
      if (infl_we)  infl_mem[lay_wa]  <= infl_wd;
      if (tick_we)  tick_mem[lay_wa]  <= tick_wd;
      if (lay_re) begin
         claim_rd_ff <= claim_mem[lidx_ff];
         infl_rd_ff  <= infl_mem[lidx_ff];
         tick_rd_ff  <= tick_mem[lidx_ff];
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff       <= CSR_RESET;
         clr_idx_ff   <= '0;
         rd_vld_ff    <= 1'b0;
         hit_found_ff <= 1'b0;
         vic_found_ff <= 1'b0;
         empty_ff     <= 1'b0;
      end else begin
         csr_ff       <= csr_in;
         clr_idx_ff   <= clr_idx_in;
         rd_vld_ff    <= rd_vld_in;
         hit_found_ff <= hit_found_in;
         vic_found_ff <= vic_found_in;
         empty_ff     <= empty_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      type_ff       <= type_in;
      expert_ff     <= expert_in;
      new_round_ff  <= new_round_in;
      oor_ff        <= oor_in;
      lidx_ff       <= lidx_in;
      base_ff       <= base_in;
      active_ff     <= active_in;
      scan_idx_ff   <= scan_idx_in;
      rd_idx_ff     <= rd_idx_in;
      hit_idx_ff    <= hit_idx_in;
      hit_freq_ff   <= hit_freq_in;
      vic_idx_ff    <= vic_idx_in;
      vic_freq_ff   <= vic_freq_in;
      vic_lu_ff     <= vic_lu_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_slot   = rsp_slot_ff;
   assign rsp_status = rsp_status_ff;

endmodule

// ===== test/tb_expert_slot_lfu_cache_policy.sv =====
// Self-checking testbench for the expert slot LFU cache: predicted slot and status per request.
module tb_expert_slot_lfu_cache_policy import eslfu_pkg::*; ();

   localparam int CACHE_ENTRIES = N_SLOTS_DEF * N_LAYERS_DEF;
   localparam int LIMIT_CYCLES  = 600000;
   localparam int HOLD_CYCLES   = 300;
   localparam int TAIL_CYCLES   = 40;

   typedef struct packed {
      logic [REQ_TYPE_W-1:0] kind;
      logic [LAYER_W-1:0]    layer;
      logic [EXPERT_W-1:0]   expert;
      logic                  new_round;
   } cache_req_type;

   typedef struct packed {
      logic [SLOT_W-1:0]   slot;
      logic [STATUS_W-1:0] status;
   } cache_rsp_type;

   logic clock;
   logic reset;
   logic csr_wr_en;
   logic [CSR_W-1:0] csr_wr_data;

   eslfu_req_if req_chan ();
   eslfu_rsp_if rsp_chan ();

   expert_slot_lfu_cache_policy dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // Local copy of the slot tables
   logic                sc_valid   [CACHE_ENTRIES];
   logic [EXPERT_W-1:0] sc_expert  [CACHE_ENTRIES];
   logic [FREQ_W-1:0]   sc_freq    [CACHE_ENTRIES];
   logic [TICK_W-1:0]   sc_last    [CACHE_ENTRIES];
   logic                sc_claimed [CACHE_ENTRIES];
   logic                sc_busy    [CACHE_ENTRIES];
   logic [TICK_W-1:0]   lay_tick   [N_LAYERS_DEF];
   logic [CSR_W-1:0]    slot_cfg;

   cache_req_type request_q [$];
   cache_rsp_type outcome_q [$];

   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int err_count = 0;
   int cycle_count = 0;
   logic hold_arm = 1'b0;
   logic hold_on;

   cache_req_type accepted;
   cache_rsp_type want;

   logic [LAYER_W-1:0]  hot_layer [4];
   logic [EXPERT_W-1:0] pool_lo   [N_LAYERS_DEF];

   // Predicted outcome of one request; updates the local slot tables
   function automatic cache_rsp_type cache_outcome(input cache_req_type r);
      cache_rsp_type o;
      int act, base, s, hit, vic, e, v;
      logic stop;
      o = '0;
      act = (slot_cfg > CSR_W'(N_SLOTS_DEF)) ? N_SLOTS_DEF : int'(slot_cfg);
      base = int'(r.layer) * N_SLOTS_DEF;
      if (r.kind == REQ_DONE) begin
         for (s = 0; s < N_SLOTS_DEF; s++) sc_busy[base + s] = 1'b0;
         o.status = ST_HIT;
         return o;
      end
      if (r.new_round) begin
         for (s = 0; s < N_SLOTS_DEF; s++) sc_claimed[base + s] = 1'b0;
      end
      hit = -1;
      for (s = 0; s < act; s++) begin
         if (hit < 0 && sc_valid[base + s] && sc_expert[base + s] == r.expert) hit = s;
      end
      if (hit >= 0) begin
         o.status = sc_claimed[base + hit] ? ST_REPEAT : ST_HIT;
      end else begin
         // victim: first empty slot, else least freq, oldest use on a tie
         vic = -1;
         stop = 1'b0;
         for (s = 0; s < act; s++) begin
            e = base + s;
            if (!stop && !sc_claimed[e] && !sc_busy[e]) begin
               if (!sc_valid[e]) begin
                  vic = s;
                  stop = 1'b1;
               end else if (vic < 0) begin
                  vic = s;
               end else begin
                  v = base + vic;
                  if (sc_freq[e] < sc_freq[v] ||
                      (sc_freq[e] == sc_freq[v] && sc_last[e] < sc_last[v]))
                     vic = s;
               end
            end
         end
         if (vic < 0) begin
            o.status = ST_NOVIC;
            return o;
         end
         hit = vic;
         sc_valid[base + hit]  = 1'b1;
         sc_expert[base + hit] = r.expert;
         sc_freq[base + hit]   = '0;
         sc_busy[base + hit]   = 1'b1;
         o.status = ST_MISS;
      end
      e = base + hit;
      if (sc_freq[e] != '1) sc_freq[e] = sc_freq[e] + 1'b1;
      if (lay_tick[r.layer] != '1) lay_tick[r.layer] = lay_tick[r.layer] + 1'b1;
      sc_last[e] = lay_tick[r.layer];
      sc_claimed[e] = 1'b1;
      o.slot = SLOT_W'(hit);
      return o;
   endfunction

   function automatic void push_req(input logic [REQ_TYPE_W-1:0] kind,
                                    input logic [LAYER_W-1:0] layer,
                                    input logic [EXPERT_W-1:0] expert,
                                    input logic new_round);
      cache_req_type r;
      r.kind = kind;
      r.layer = layer;
      r.expert = expert;
      r.new_round = new_round;
      request_q = {request_q, r};
   endfunction

   // Wait until no request is pending, offered or awaiting its response
   task automatic drain();
      do @(negedge clock);
      while (request_q.size() != 0 || req_chan.valid || outcome_q.size() != 0);
   endtask

   task automatic write_slots(input logic [CSR_W-1:0] value);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      slot_cfg = value;
      @(negedge clock);
   endtask

   task automatic start_phase(input int cfg, input int s_pct, input int r_pct);
      drain();
      write_slots(CSR_W'(cfg));
      send_idle_pct = s_pct;
      recv_stall_pct = r_pct;
   endtask

   // Mostly well-formed rounds on a few busy layers, some noise and open rounds
   task automatic fill_phase(input int n, input int act);
      logic [LAYER_W-1:0] lay;
      int len, pool, k;
      while (request_q.size() < n) begin
         if ($urandom_range(9) == 0) begin
            push_req(REQ_TYPE_W'($urandom_range(1)), LAYER_W'($urandom_range(63)),
                     EXPERT_W'($urandom_range(1023)), 1'($urandom_range(1)));
         end else begin
            lay = hot_layer[$urandom_range(3)];
            pool = act + int'($urandom_range(act + 2));
            len = int'($urandom_range(act + 4, 1));
            for (k = 0; k < len; k++)
               push_req(REQ_LOOKUP, lay,
                        pool_lo[lay] + EXPERT_W'($urandom_range(pool - 1)),
                        (k == 0) || ($urandom_range(19) == 0));
            if ($urandom_range(99) < 85)
               push_req(REQ_DONE, lay, EXPERT_W'($urandom), 1'($urandom_range(1)));
         end
      end
   endtask

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Run limit
   initial begin
      while (cycle_count < LIMIT_CYCLES) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("DONE: errors detected");
      $finish;
   end

   // Long receiver hold-off, armed once by the stimulus
   initial begin
      hold_on = 1'b0;
      wait (hold_arm);
      @(posedge clock);
      hold_on <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_on <= 1'b0;
   end

   // Request driver; predicts each request as it is accepted
   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            accepted.kind      = req_chan.req_type;
            accepted.layer     = req_chan.layer;
            accepted.expert    = req_chan.expert;
            accepted.new_round = req_chan.new_round;
            outcome_q = {outcome_q, cache_outcome(accepted)};
         end
         if (!req_chan.valid || req_chan.ready) begin
            if (request_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_chan.req_type  <= request_q[0].kind;
               req_chan.layer     <= request_q[0].layer;
               req_chan.expert    <= request_q[0].expert;
               req_chan.new_round <= request_q[0].new_round;
               req_chan.valid     <= 1'b1;
               request_q.delete(0);
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   // Response ready with random stalls
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= !hold_on && ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Response monitor
   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (outcome_q.size() == 0) begin
            $display("%0t: unexpected response, expected none, got slot %0d status %0d",
                     $time, rsp_chan.slot, rsp_chan.status);
            err_count++;
         end else begin
            want = outcome_q[0];
            outcome_q.delete(0);
            if (rsp_chan.slot !== want.slot) begin
               $display("%0t: slot mismatch, expected %0d, got %0d",
                        $time, want.slot, rsp_chan.slot);
               err_count++;
            end
            if (rsp_chan.status !== want.status) begin
               $display("%0t: status mismatch, expected %0d, got %0d",
                        $time, want.status, rsp_chan.status);
               err_count++;
            end
         end
      end
   end

   // Stimulus
   initial begin
      int cfg_plan [12] = '{16, 4, 1, 31, 2, 0, 8, 16, 3, 12, 20, 6};
      int send_plan [4] = '{0, 58, 0, 12};
      int recv_plan [4] = '{0, 0, 58, 12};
      int ph, eff, n, i;

      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      req_chan.valid = 1'b0;
      req_chan.req_type = REQ_LOOKUP;
      req_chan.layer = '0;
      req_chan.expert = '0;
      req_chan.new_round = 1'b0;
      rsp_chan.ready = 1'b0;
      for (i = 0; i < CACHE_ENTRIES; i++) begin
         sc_valid[i] = 1'b0;
         sc_expert[i] = '0;
         sc_freq[i] = '0;
         sc_last[i] = '0;
         sc_claimed[i] = 1'b0;
         sc_busy[i] = 1'b0;
      end
      for (i = 0; i < N_LAYERS_DEF; i++) begin
         lay_tick[i] = '0;
         pool_lo[i] = EXPERT_W'($urandom_range(1023));
      end
      slot_cfg = CSR_RESET;
      hot_layer[0] = '0;
      hot_layer[1] = '1;

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Field extremes, repeat and counted hits, done with junk fields
      push_req(REQ_LOOKUP, 6'd0, 10'd0, 1'b1);
      push_req(REQ_LOOKUP, 6'd0, 10'd0, 1'b0);
      push_req(REQ_LOOKUP, 6'd63, 10'd1023, 1'b1);
      push_req(REQ_LOOKUP, 6'd63, 10'd1022, 1'b0);
      push_req(REQ_DONE, 6'd0, 10'd1023, 1'b1);
      push_req(REQ_LOOKUP, 6'd0, 10'd0, 1'b1);
      push_req(REQ_DONE, 6'd63, 10'd0, 1'b0);

      // One slot: claimed and in-flight slots give no victim
      start_phase(1, 0, 0);
      push_req(REQ_LOOKUP, 6'd5, 10'd7, 1'b1);
      push_req(REQ_LOOKUP, 6'd5, 10'd8, 1'b0);
      push_req(REQ_DONE, 6'd5, 10'd0, 1'b0);
      push_req(REQ_LOOKUP, 6'd5, 10'd8, 1'b0);
      push_req(REQ_LOOKUP, 6'd5, 10'd8, 1'b1);

      // Zero active slots: even a resident expert is not found
      start_phase(0, 0, 0);
      push_req(REQ_LOOKUP, 6'd0, 10'd0, 1'b1);
      push_req(REQ_DONE, 6'd0, 10'd0, 1'b1);

      // Two slots: least-frequency pick and oldest-use tie-break
      start_phase(2, 0, 0);
      push_req(REQ_LOOKUP, 6'd9, 10'd1, 1'b1);
      push_req(REQ_LOOKUP, 6'd9, 10'd2, 1'b0);
      push_req(REQ_DONE, 6'd9, 10'd0, 1'b0);
      push_req(REQ_LOOKUP, 6'd9, 10'd1, 1'b1);
      push_req(REQ_LOOKUP, 6'd9, 10'd3, 1'b1);
      push_req(REQ_DONE, 6'd9, 10'd0, 1'b0);
      push_req(REQ_LOOKUP, 6'd9, 10'd4, 1'b1);
      push_req(REQ_LOOKUP, 6'd10, 10'd1, 1'b1);
      push_req(REQ_LOOKUP, 6'd10, 10'd2, 1'b0);
      push_req(REQ_DONE, 6'd10, 10'd0, 1'b0);
      push_req(REQ_LOOKUP, 6'd10, 10'd3, 1'b1);

      // Random phases across slot counts and idle patterns
      for (ph = 0; ph < 12; ph++) begin
         if (ph == 7) begin
            start_phase(cfg_plan[ph], 0, 0);
            hold_arm = 1'b1;
         end else begin
            start_phase(cfg_plan[ph], send_plan[ph % 4], recv_plan[ph % 4]);
         end
         hot_layer[2] = LAYER_W'($urandom_range(63));
         hot_layer[3] = LAYER_W'($urandom_range(63));
         if (ph % 2 == 1) begin
            for (i = 0; i < 4; i++) pool_lo[hot_layer[i]] = EXPERT_W'($urandom_range(1023));
         end
         eff = (cfg_plan[ph] > N_SLOTS_DEF) ? N_SLOTS_DEF : cfg_plan[ph];
         n = (eff == 0) ? 30 : 100;
         if (eff == 0) eff = 4;
         fill_phase(n, eff);
      end

      drain();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (err_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
